FILE: hw/rtl/bpsd_pkg.sv
package bpsd_pkg;

	typedef enum logic [1:0] {
		FMT_BGR24  = 2'd0,
		FMT_BGRX32 = 2'd1,
		FMT_PAL8   = 2'd2,
		FMT_RSVD   = 2'd3
	} fmt_t;

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_PAL  = 4'b0010,
		PH_PIX  = 4'b0100,
		PH_DONE = 4'b1000
	} phase_t;

	localparam int unsigned ADDR_W = 5;

	localparam logic [ADDR_W-1:0] REG_FORMAT   = 5'd0;
	localparam logic [ADDR_W-1:0] REG_WIDTH    = 5'd4;
	localparam logic [ADDR_W-1:0] REG_HEIGHT   = 5'd8;
	localparam logic [ADDR_W-1:0] REG_ORIGIN_X = 5'd12;
	localparam logic [ADDR_W-1:0] REG_ORIGIN_Y = 5'd16;
	localparam logic [ADDR_W-1:0] REG_PAL_SIZE = 5'd20;

	typedef struct packed {
		fmt_t        fmt;
		logic [11:0] width;
		logic [11:0] height;
		logic [15:0] origin_x;
		logic [15:0] origin_y;
		logic [7:0]  pal_size;
	} cfg_t;

	typedef struct packed {
		logic        valid;
		logic [15:0] x;
		logic [15:0] y;
		logic [23:0] color;
		logic        use_pal;
		logic        pal_ok;
		logic        last;
	} emit_t;

	typedef struct packed {
		logic        we;
		logic [7:0]  addr;
		logic [23:0] data;
	} pal_wr_t;

endpackage

FILE: hw/rtl/bmp_pixel_stream_decoder_top.sv
// Channel   Direction  Transfer carries
// s_*       in         tdata = data_byte; tuser = frame_start
// m_*       out        tdata = pixel_x, pixel_y, pixel_color; tlast = last_pixel
// APB       in/out     six configuration registers at byte addresses 0 to 20
//
// One byte is taken every cycle while s_tready is high, with or without a pixel resulting from it.
// After its last byte is taken, a pixel passes first through the palette lookup
// stage and then through the output register before it appears on m_*.
// A stalled output holds one pixel in the output register and one in the
// lookup stage before s_tready drops. Reset clears all counters and valids;
// the palette memory holds unknown data until it is loaded.
module bmp_pixel_stream_decoder_top #(
	parameter int unsigned PALETTE_DEPTH      = 256,
	parameter int unsigned MAX_DIMENSION_BITS = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,   // [7:0] data_byte
	input  logic                        s_tuser,   // [0] frame_start
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [55:0]                 m_tdata,   // [15:0] pixel_x, [31:16] pixel_y,
	                                               // [55:32] pixel_color
	output logic                        m_tlast,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bpsd_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	bpsd_pkg::cfg_t    cfg;
	bpsd_pkg::emit_t   emit;
	bpsd_pkg::pal_wr_t pal_wr;
	logic              accept;
	logic [23:0]       pal_data;

	assign accept = s_tvalid && s_tready;

	bpsd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bpsd_parse #(
		.PALETTE_DEPTH      (PALETTE_DEPTH),
		.MAX_DIMENSION_BITS (MAX_DIMENSION_BITS)
	) u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.accept      (accept),
		.data_byte   (s_tdata),
		.frame_start (s_tuser),
		.emit        (emit),
		.pal_wr      (pal_wr)
	);

	bpsd_pal #(
		.PALETTE_DEPTH (PALETTE_DEPTH)
	) u_pal (
		.clk     (clk),
		.pal_wr  (pal_wr),
		.rd_en   (accept && emit.valid),
		.rd_addr (s_tdata),
		.rd_data (pal_data)
	);

	bpsd_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.emit     (emit),
		.accept   (accept),
		.pal_data (pal_data),
		.in_ready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

FILE: hw/rtl/bpsd_cfg.sv
module bpsd_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bpsd_pkg::ADDR_W-1:0]    paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	output bpsd_pkg::cfg_t                 cfg
);

	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.fmt      <= bpsd_pkg::FMT_BGR24;
			cfg.width    <= 12'd1;
			cfg.height   <= 12'd1;
			cfg.origin_x <= '0;
			cfg.origin_y <= '0;
			cfg.pal_size <= '0;
		end else if (wr_en) begin
			unique case (paddr)
				bpsd_pkg::REG_FORMAT:   cfg.fmt      <= bpsd_pkg::fmt_t'(pwdata[1:0]);
				bpsd_pkg::REG_WIDTH:    cfg.width    <= pwdata[11:0];
				bpsd_pkg::REG_HEIGHT:   cfg.height   <= pwdata[11:0];
				bpsd_pkg::REG_ORIGIN_X: cfg.origin_x <= pwdata[15:0];
				bpsd_pkg::REG_ORIGIN_Y: cfg.origin_y <= pwdata[15:0];
				bpsd_pkg::REG_PAL_SIZE: cfg.pal_size <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr)
			bpsd_pkg::REG_FORMAT:   prdata = {30'd0, cfg.fmt};
			bpsd_pkg::REG_WIDTH:    prdata = {20'd0, cfg.width};
			bpsd_pkg::REG_HEIGHT:   prdata = {20'd0, cfg.height};
			bpsd_pkg::REG_ORIGIN_X: prdata = {16'd0, cfg.origin_x};
			bpsd_pkg::REG_ORIGIN_Y: prdata = {16'd0, cfg.origin_y};
			bpsd_pkg::REG_PAL_SIZE: prdata = {24'd0, cfg.pal_size};
			default:                prdata = '0;
		endcase
	end

endmodule

FILE: hw/rtl/bpsd_parse.sv
module bpsd_parse #(
	parameter int unsigned PALETTE_DEPTH      = 256,
	parameter int unsigned MAX_DIMENSION_BITS = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bpsd_pkg::cfg_t    cfg,
	input  logic              accept,
	input  logic [7:0]        data_byte,
	input  logic              frame_start,
	output bpsd_pkg::emit_t   emit,
	output bpsd_pkg::pal_wr_t pal_wr
);

	localparam int unsigned DW = MAX_DIMENSION_BITS;

	bpsd_pkg::phase_t phase_q, phase_n;
	logic [9:0]    pal_cnt_q, pal_cnt_n;
	logic [1:0]    bip_q, bip_n;
	logic [15:0]   pc_q, pc_n;
	logic [DW-1:0] col_q, col_n;
	logic [DW-1:0] row_q, row_n;
	logic [1:0]    pad_q, pad_n;

	logic [DW-1:0] w_m, h_m, w1, h1, col_inc, row_inc;
	logic [8:0]    entries;
	logic [10:0]   pal_lim;
	logic [1:0]    row_pad;
	logic          fin_pixel, fin_row;

	assign w_m     = DW'(cfg.width);
	assign h_m     = DW'(cfg.height);
	assign w1      = w_m - DW'(1);
	assign h1      = h_m - DW'(1);
	assign entries = (cfg.pal_size == 8'd0) ? 9'd256 : {1'b0, cfg.pal_size};
	assign pal_lim = {entries, 2'b00} - 11'd1;

	always_comb begin
		unique case (cfg.fmt)
			bpsd_pkg::FMT_PAL8:   row_pad = 2'd0 - cfg.width[1:0];
			bpsd_pkg::FMT_BGRX32: row_pad = 2'd0;
			default:              row_pad = cfg.width[1:0];
		endcase
	end

	always_comb begin
		phase_n   = phase_q;
		pal_cnt_n = pal_cnt_q;
		bip_n     = bip_q;
		pc_n      = pc_q;
		col_n     = col_q;
		row_n     = row_q;
		pad_n     = pad_q;
		fin_pixel = 1'b0;
		fin_row   = 1'b0;
		col_inc   = '0;
		row_inc   = '0;
		emit      = '0;
		pal_wr    = '0;

		if (frame_start) begin
			pal_cnt_n = '0;
			bip_n     = '0;
			pc_n      = '0;
			col_n     = '0;
			row_n     = '0;
			pad_n     = '0;
			if (cfg.fmt == bpsd_pkg::FMT_PAL8) begin
				phase_n = bpsd_pkg::PH_PAL;
			end else if (cfg.fmt == bpsd_pkg::FMT_RSVD) begin
				phase_n = bpsd_pkg::PH_IDLE;
			end else begin
				phase_n = bpsd_pkg::PH_PIX;
			end
		end

		emit.x    = cfg.origin_x + 16'(col_n);
		emit.y    = cfg.origin_y + 16'(DW'(h1 - row_n));
		emit.last = (col_n == w1) && (row_n == h1);

		if (phase_n == bpsd_pkg::PH_PAL) begin
			case (pal_cnt_n[1:0])
				2'd0: pc_n = {8'd0, data_byte};
				2'd1: pc_n = {data_byte, pc_n[7:0]};
				2'd2: begin
					pal_wr.we   = ({1'b0, pal_cnt_n[9:2]} < 9'(PALETTE_DEPTH));
					pal_wr.addr = pal_cnt_n[9:2];
					pal_wr.data = {data_byte, pc_n};
				end
				default: ;
			endcase
			if ({1'b0, pal_cnt_n} >= pal_lim) begin
				phase_n = bpsd_pkg::PH_PIX;
			end else begin
				pal_cnt_n = pal_cnt_n + 10'd1;
			end
		end else if (phase_n == bpsd_pkg::PH_PIX) begin
			if (pad_n != 2'd0) begin
				pad_n = pad_n - 2'd1;
				fin_row = (pad_n == 2'd0);
			end else if (bip_n == 2'd3) begin
				bip_n = 2'd0;
				fin_pixel = 1'b1;
			end else if (cfg.fmt == bpsd_pkg::FMT_PAL8) begin
				emit.valid   = 1'b1;
				emit.use_pal = 1'b1;
				emit.pal_ok  = ({1'b0, data_byte} < entries) &&
					({1'b0, data_byte} < 9'(PALETTE_DEPTH));
				fin_pixel = 1'b1;
			end else if (cfg.fmt != bpsd_pkg::FMT_RSVD) begin
				if (bip_n == 2'd0) begin
					pc_n  = {8'd0, data_byte};
					bip_n = 2'd1;
				end else if (bip_n == 2'd1) begin
					pc_n  = {data_byte, pc_n[7:0]};
					bip_n = 2'd2;
				end else begin
					emit.valid = 1'b1;
					emit.color = {data_byte, pc_n};
					if (cfg.fmt == bpsd_pkg::FMT_BGRX32) begin
						bip_n = 2'd3;
					end else begin
						bip_n = 2'd0;
						fin_pixel = 1'b1;
					end
				end
			end
		end

		if (fin_pixel) begin
			col_inc = col_n + DW'(1);
			if (col_inc == w_m) begin
				col_n = '0;
				if (row_pad != 2'd0) begin
					pad_n = row_pad;
				end else begin
					fin_row = 1'b1;
				end
			end else begin
				col_n = col_inc;
			end
		end

		if (fin_row) begin
			row_inc = row_n + DW'(1);
			row_n   = row_inc;
			if (row_inc == h_m) begin
				phase_n = bpsd_pkg::PH_DONE;
			end
		end

		if (!accept) begin
			emit.valid = 1'b0;
			pal_wr.we  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= bpsd_pkg::PH_IDLE;
			pal_cnt_q <= '0;
			bip_q     <= '0;
			pc_q      <= '0;
			col_q     <= '0;
			row_q     <= '0;
			pad_q     <= '0;
		end else if (accept) begin
			phase_q   <= phase_n;
			pal_cnt_q <= pal_cnt_n;
			bip_q     <= bip_n;
			pc_q      <= pc_n;
			col_q     <= col_n;
			row_q     <= row_n;
			pad_q     <= pad_n;
		end
	end

endmodule

FILE: hw/rtl/bpsd_pal.sv
module bpsd_pal #(
	parameter int unsigned PALETTE_DEPTH = 256
) (
	input  logic              clk,
	input  bpsd_pkg::pal_wr_t pal_wr,
	input  logic              rd_en,
	input  logic [7:0]        rd_addr,
	output logic [23:0]       rd_data
);

	localparam int unsigned AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

	logic [23:0] mem [PALETTE_DEPTH];

	always_ff @(posedge clk) begin
		if (pal_wr.we) begin
			mem[pal_wr.addr[AW-1:0]] <= pal_wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr[AW-1:0]];
		end
	end

endmodule

FILE: hw/rtl/bpsd_out.sv
module bpsd_out (
	input  logic            clk,
	input  logic            arst_n,
	input  bpsd_pkg::emit_t emit,
	input  logic            accept,
	input  logic [23:0]     pal_data,
	output logic            in_ready,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [55:0]     m_tdata,
	output logic            m_tlast
);

	logic            s1_valid_q;
	bpsd_pkg::emit_t emit_s1;
	logic            s1_adv;
	logic [23:0]     color_s1;

	assign s1_adv   = s1_valid_q && (!m_tvalid || m_tready);
	assign in_ready = !s1_valid_q || s1_adv;

	always_comb begin
		if (!emit_s1.use_pal) begin
			color_s1 = emit_s1.color;
		end else if (emit_s1.pal_ok) begin
			color_s1 = pal_data;
		end else begin
			color_s1 = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			m_tvalid   <= 1'b0;
		end else begin
			if (accept && emit.valid) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit.valid) begin
			emit_s1 <= emit;
		end
		if (s1_adv) begin
			m_tdata <= {color_s1, emit_s1.y, emit_s1.x};
			m_tlast <= emit_s1.last;
		end
	end

endmodule

FILE: hw/rtl/bpsd_checker.sv
module bpsd_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic [7:0]                  s_tdata,
	input logic                        s_tuser,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [55:0]                 m_tdata,
	input logic                        m_tlast,
	input logic                        psel,
	input logic                        penable,
	input logic                        pwrite,
	input logic [bpsd_pkg::ADDR_W-1:0] paddr,
	input logic [31:0]                 pwdata,
	input logic [31:0]                 prdata,
	input logic                        pready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("Stalled output transfer changed.");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("Input not ready while the output register is empty.");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("Configuration port inserted a wait state.");

	a_width_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && paddr == bpsd_pkg::REG_WIDTH
		|=> paddr != bpsd_pkg::REG_WIDTH || prdata == {20'd0, $past(pwdata[11:0])})
		else $error("Width register does not read back the written value.");

endmodule

bind bmp_pixel_stream_decoder_top bpsd_checker u_bpsd_checker (.*);
